/* hdl/stg_pkg.sv */
// ----------------------------------------------------------------------------
// stg_pkg
// Shared constants, pipeline stage types and the quarter-wave sine table
// builder for the DDS tone generator.
// ----------------------------------------------------------------------------
package stg_pkg;

    localparam int SAMPLE_RATE     = 16000;
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int TABLE_SIZE      = 1 << TABLE_ADDR_BITS;

    localparam int FREQ_BITS      = 16;
    localparam int MS_BITS        = 16;
    localparam int VOL_BITS       = 8;
    localparam int COUNT_BITS     = 20;
    localparam int AMP_BITS       = 15;
    localparam int MAG_BITS       = 15;
    localparam int SAMPLE_BITS    = 16;
    localparam int PROD_BITS      = AMP_BITS + MAG_BITS;
    localparam int VOL_CLAMP_BITS = 7;

    localparam int FULL_SCALE = 32767;
    localparam int VOL_MAX    = 100;
    localparam int MS_PER_S   = 1000;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Phase step: floor(freq * 2^PHASE_BITS / SAMPLE_RATE) as a reciprocal
    // multiply, exact because 2^STEP_SHIFT exceeds freq * SAMPLE_RATE.
    localparam int STEP_SHIFT     = 32;
    localparam int STEP_MUL_BITS  = PHASE_BITS + STEP_SHIFT - 12;
    localparam logic [79:0] STEP_NUM = 80'(1) << (PHASE_BITS + STEP_SHIFT);
    localparam logic [79:0] STEP_MUL_FULL =
        (STEP_NUM + 80'(SAMPLE_RATE - 1)) / 80'(SAMPLE_RATE);
    localparam int STEP_LO_BITS   = STEP_MUL_BITS / 2;
    localparam int STEP_HI_BITS   = STEP_MUL_BITS - STEP_LO_BITS;
    localparam logic [STEP_LO_BITS-1:0] STEP_MUL_LO = STEP_MUL_FULL[STEP_LO_BITS-1:0];
    localparam logic [STEP_HI_BITS-1:0] STEP_MUL_HI =
        STEP_MUL_FULL[STEP_MUL_BITS-1:STEP_LO_BITS];
    localparam int STEP_LO_PROD_BITS = FREQ_BITS + STEP_LO_BITS;
    localparam int STEP_HI_PROD_BITS = FREQ_BITS + STEP_HI_BITS;
    localparam int STEP_SUM_BITS     = FREQ_BITS + STEP_MUL_BITS + 1;

    // Sample count: floor(SAMPLE_RATE * ms / 1000), exact since 2^26 > 1000 * ms
    localparam int CNT_SHIFT     = 26;
    localparam int CNT_MUL_BITS  = 32;
    localparam logic [CNT_MUL_BITS-1:0] CNT_MUL = CNT_MUL_BITS'(
        ((64'(SAMPLE_RATE) << CNT_SHIFT) + 64'(MS_PER_S - 1)) / 64'(MS_PER_S));
    localparam int CNT_PROD_BITS = MS_BITS + CNT_MUL_BITS;
    localparam int CNT_Q_BITS    = CNT_PROD_BITS - CNT_SHIFT;

    // Amplitude: floor(32767 * vol / 100), exact since 2^14 > 100 * vol
    localparam int AMP_SHIFT     = 14;
    localparam int AMP_MUL_BITS  = 23;
    localparam logic [AMP_MUL_BITS-1:0] AMP_MUL = AMP_MUL_BITS'(
        ((64'(FULL_SCALE) << AMP_SHIFT) + 64'(VOL_MAX - 1)) / 64'(VOL_MAX));
    localparam int AMP_PROD_BITS = VOL_CLAMP_BITS + AMP_MUL_BITS;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_Q30    = 64'd1 << 29;

    typedef logic [TABLE_SIZE:0][MAG_BITS-1:0] sine_tab_t;

    typedef struct packed {
        logic                  valid;
        logic                  command;
        logic [FREQ_BITS-1:0]  freq_hz;
        logic [MS_BITS-1:0]    length_ms;
        logic [VOL_BITS-1:0]   level_pct;
    } stg_item_t;

    typedef struct packed {
        logic                  valid;
        logic                  tick;
        logic                  load;
        logic [PHASE_BITS-1:0] step;
        logic [COUNT_BITS-1:0] count;
        logic [AMP_BITS-1:0]   amp;
    } stg_setup_t;

    typedef struct packed {
        logic                  valid;
        logic                  neg;
        logic                  last;
        logic [AMP_BITS-1:0]   amp;
        logic [MAG_BITS-1:0]   mag;
    } stg_lookup_t;

    // Quarter-wave table, Q0.15, via a Taylor series in Q2.30
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] e;
        for (int k = 0; k <= TABLE_SIZE; k++) begin
            x  = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
            s  = (x * t) >> 30;
            e  = (64'(FULL_SCALE) * s + HALF_Q30) >> 30;
            if (e > 64'(FULL_SCALE))
            begin
                e = 64'(FULL_SCALE);
            end
            tab[k] = MAG_BITS'(e);
        end
        return tab;
    endfunction

endpackage

/* hdl/stg_setup.sv */
// ----------------------------------------------------------------------------
// stg_setup
// Start-command arithmetic: phase step, sample count and amplitude by
// constant reciprocal multiplies, registered, then scaled and clamped.
// ----------------------------------------------------------------------------
module stg_setup
    import stg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  stg_item_t  item,
    output stg_setup_t setup
);

    logic                         valid_reg;
    logic                         command_reg;
    logic                         skip_reg;
    logic [STEP_HI_PROD_BITS-1:0] step_hi_reg;
    logic [STEP_LO_PROD_BITS-1:0] step_lo_reg;
    logic [CNT_PROD_BITS-1:0]     cnt_prod_reg;
    logic [AMP_PROD_BITS-1:0]     amp_prod_reg;

    logic [VOL_CLAMP_BITS-1:0]    vol_clamp;
    logic [STEP_SUM_BITS-1:0]     step_sum;
    logic [CNT_Q_BITS-1:0]        cnt_q;
    logic [COUNT_BITS-1:0]        count;

    assign vol_clamp = (item.level_pct > VOL_BITS'(VOL_MAX)) ? VOL_CLAMP_BITS'(VOL_MAX)
                                                             : item.level_pct[VOL_CLAMP_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            command_reg  <= item.command;
            skip_reg     <= (item.freq_hz == '0) || (item.length_ms == '0);
            step_hi_reg  <= STEP_HI_PROD_BITS'(item.freq_hz) * STEP_HI_PROD_BITS'(STEP_MUL_HI);
            step_lo_reg  <= STEP_LO_PROD_BITS'(item.freq_hz) * STEP_LO_PROD_BITS'(STEP_MUL_LO);
            cnt_prod_reg <= CNT_PROD_BITS'(item.length_ms) * CNT_PROD_BITS'(CNT_MUL);
            amp_prod_reg <= AMP_PROD_BITS'(vol_clamp) * AMP_PROD_BITS'(AMP_MUL);
        end
    end

    assign step_sum = STEP_SUM_BITS'({step_hi_reg, {STEP_LO_BITS{1'b0}}})
                    + STEP_SUM_BITS'(step_lo_reg);
    assign cnt_q    = cnt_prod_reg[CNT_PROD_BITS-1:CNT_SHIFT];
    // saturate long tones
    assign count    = (cnt_q > CNT_Q_BITS'(COUNT_MAX)) ? COUNT_MAX : cnt_q[COUNT_BITS-1:0];

    always_comb
    begin
        setup.valid = valid_reg;
        setup.tick  = valid_reg && (command_reg == CMD_TICK);
        setup.load  = valid_reg && (command_reg == CMD_START) && !skip_reg && (count != '0);
        setup.step  = step_sum[STEP_SHIFT +: PHASE_BITS];
        setup.count = count;
        setup.amp   = amp_prod_reg[AMP_SHIFT +: AMP_BITS];
    end

endmodule

/* hdl/stg_osc.sv */
// ----------------------------------------------------------------------------
// stg_osc
// Tone state: phase accumulator, step, countdown and amplitude. Each tick
// reads the quarter-wave table with a registered read and advances state.
// ----------------------------------------------------------------------------
module stg_osc
    import stg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  stg_setup_t  setup,
    output stg_lookup_t lookup
);

    localparam sine_tab_t SINE_ROM = build_sine_tab();

    logic [PHASE_BITS-1:0]      phase_acc_reg;
    logic [PHASE_BITS-1:0]      phase_step_reg;
    logic [COUNT_BITS-1:0]      samples_left_reg;
    logic [AMP_BITS-1:0]        amplitude_reg;
    logic                       running_reg;

    logic                       lk_valid_reg;
    logic                       lk_neg_reg;
    logic                       lk_last_reg;
    logic [AMP_BITS-1:0]        lk_amp_reg;
    logic [MAG_BITS-1:0]        lk_mag_reg;

    logic                       tick;
    logic                       final_tick;
    logic [TABLE_ADDR_BITS+1:0] phase_top;
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] idx;
    logic [TABLE_ADDR_BITS:0]   rom_addr;

    assign tick       = setup.tick && running_reg;
    assign final_tick = (samples_left_reg == COUNT_BITS'(1));

    assign phase_top = phase_acc_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS+2];
    assign quad      = phase_top[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
    assign idx       = phase_top[TABLE_ADDR_BITS-1:0];
    // mirror the table on odd quadrants
    assign rom_addr  = quad[0] ? ((TABLE_ADDR_BITS+1)'(TABLE_SIZE) - {1'b0, idx})
                               : {1'b0, idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            phase_step_reg   <= '0;
            samples_left_reg <= '0;
            amplitude_reg    <= '0;
            running_reg      <= 1'b0;
            lk_valid_reg     <= 1'b0;
        end
        else if (adv)
        begin
            lk_valid_reg <= tick;
            if (setup.load)
            begin
                phase_acc_reg    <= '0;
                phase_step_reg   <= setup.step;
                samples_left_reg <= setup.count;
                amplitude_reg    <= setup.amp;
                running_reg      <= 1'b1;
            end
            else if (tick)
            begin
                phase_acc_reg    <= phase_acc_reg + phase_step_reg;
                samples_left_reg <= samples_left_reg - COUNT_BITS'(1);
                if (final_tick)
                begin
                    running_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lk_mag_reg  <= SINE_ROM[rom_addr];
            lk_amp_reg  <= amplitude_reg;
            lk_neg_reg  <= quad[1];
            lk_last_reg <= final_tick;
        end
    end

    always_comb
    begin
        lookup.valid = lk_valid_reg;
        lookup.neg   = lk_neg_reg;
        lookup.last  = lk_last_reg;
        lookup.amp   = lk_amp_reg;
        lookup.mag   = lk_mag_reg;
    end

    a_running_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (samples_left_reg != '0))
        else $error("tone running with zero samples left");

    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (lk_valid_reg && lk_last_reg) |-> !running_reg)
        else $error("final sample issued while tone still running");

endmodule

/* hdl/stg_scale.sv */
// ----------------------------------------------------------------------------
// stg_scale
// Amplitude scaling: amp * table value, divide by 32767 with one
// correction step, apply quadrant sign and hold the result for transfer.
// ----------------------------------------------------------------------------
module stg_scale
    import stg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  stg_lookup_t                   lookup,
    output logic                          sample_valid,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          last
);

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                   pr_valid_reg;
    logic                   pr_neg_reg;
    logic                   pr_last_reg;
    logic [PROD_BITS-1:0]   pr_prod_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   last_reg;

    logic [AMP_BITS-1:0]    q_hi;
    logic [AMP_BITS:0]      q_rem;
    logic [AMP_BITS-1:0]    quot;
    logic [SAMPLE_BITS-1:0] mag_ext;
    logic [SAMPLE_BITS-1:0] sample_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            pr_valid_reg  <= lookup.valid;
            out_valid_reg <= pr_valid_reg;
        end
    end

    // x / 32767 = (x >> 15) plus a carry when (x mod 32768) + (x >> 15) >= 32767
    assign q_hi        = pr_prod_reg[PROD_BITS-1:AMP_BITS];
    assign q_rem       = {1'b0, pr_prod_reg[AMP_BITS-1:0]} + {1'b0, q_hi};
    assign quot        = (q_rem >= (AMP_BITS+1)'(FULL_SCALE)) ? (q_hi + AMP_BITS'(1)) : q_hi;
    assign mag_ext     = {1'b0, quot};
    assign sample_next = pr_neg_reg ? (SAMPLE_BITS'(0) - mag_ext) : mag_ext;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_prod_reg <= PROD_BITS'(lookup.amp) * PROD_BITS'(lookup.mag);
            pr_neg_reg  <= lookup.neg;
            pr_last_reg <= lookup.last;
            sample_reg  <= sample_next;
            last_reg    <= pr_last_reg;
        end
    end

    assign sample_valid = out_valid_reg;
    assign sample       = sample_reg;
    assign last         = last_reg;

    a_sample_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (sample_reg != SAMPLE_MIN))
        else $error("sample outside symmetric range");

endmodule

/* hdl/sine_tone_generator.sv */
// Path: an accepted tick passes the input, setup, lookup, product and output registers to sample_valid.
// Throughput: one item per cycle; every stage advances whenever the output
// register is empty or its sample is taken in the same cycle.
// Reset: rst_n clears the tone state (idle, phase, step, count, amplitude) and
// all stage valid bits at once; no sample is pending after reset.
// ----------------------------------------------------------------------------
// sine_tone_generator
// DDS sine tone generator: input register, start arithmetic, oscillator
// with quarter-wave table, amplitude scaling and output register.
// ----------------------------------------------------------------------------
module sine_tone_generator
    import stg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tone_valid,
    output logic                          tone_ready,
    input  logic                          command,
    input  logic [FREQ_BITS-1:0]          freq_hz,
    input  logic [MS_BITS-1:0]            length_ms,
    input  logic [VOL_BITS-1:0]           level_pct,
    output logic                          sample_valid,
    input  logic                          sample_ready,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          last
);

    logic                 adv;
    logic                 in_valid_reg;
    logic                 command_reg;
    logic [FREQ_BITS-1:0] freq_hz_reg;
    logic [MS_BITS-1:0]   length_ms_reg;
    logic [VOL_BITS-1:0]  level_pct_reg;

    stg_item_t            item;
    stg_setup_t           setup;
    stg_lookup_t          lookup;

    // advance the whole pipe unless a finished sample is held
    assign adv        = !sample_valid || sample_ready;
    assign tone_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg <= tone_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            command_reg   <= command;
            freq_hz_reg   <= freq_hz;
            length_ms_reg <= length_ms;
            level_pct_reg <= level_pct;
        end
    end

    always_comb
    begin
        item.valid     = in_valid_reg;
        item.command   = command_reg;
        item.freq_hz   = freq_hz_reg;
        item.length_ms = length_ms_reg;
        item.level_pct = level_pct_reg;
    end

    stg_setup u_setup (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .item  (item),
        .setup (setup)
    );

    stg_osc u_osc (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .setup  (setup),
        .lookup (lookup)
    );

    stg_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .lookup       (lookup),
        .sample_valid (sample_valid),
        .sample       (sample),
        .last         (last)
    );

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DDS sine tone generator. Start and tick
// transfers drive the block; a scoreboard recomputes the sine table, phase,
// sample count and amplitude in integer arithmetic and compares every
// sample and last flag in order. Both handshakes idle at random, and one
// long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    import stg_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int ITEM_TARGET = 750;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } tone_sample_t;

    class tone_scoreboard;
        logic [MAG_BITS-1:0]   sine_mag [TABLE_SIZE+1];
        logic [PHASE_BITS-1:0] phase;
        logic [PHASE_BITS-1:0] step;
        logic [COUNT_BITS-1:0] remaining;
        logic [AMP_BITS-1:0]   amp;
        bit                    active;
        tone_sample_t          due_samples [$];
        int                    mismatches;

        // Quarter-wave magnitude table, Taylor series in Q2.30
        function new();
            int unsigned divisor [6] = '{156, 110, 72, 42, 20, 6};
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] t;
            logic [63:0] s;
            logic [63:0] e;
            for (int k = 0; k <= TABLE_SIZE; k++)
            begin
                x  = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
                x2 = (x * x) >> 30;
                t  = ONE_Q30;
                for (int j = 0; j < 6; j++)
                begin
                    t = ONE_Q30 - (((x2 * t) >> 30) / 64'(divisor[j]));
                end
                s = (x * t) >> 30;
                e = (64'(FULL_SCALE) * s + HALF_Q30) >> 30;
                if (e > 64'(FULL_SCALE))
                begin
                    e = 64'(FULL_SCALE);
                end
                sine_mag[k] = MAG_BITS'(e);
            end
            phase      = '0;
            step       = '0;
            remaining  = '0;
            amp        = '0;
            active     = 1'b0;
            mismatches = 0;
        endfunction

        // Update the tone state for one accepted transfer; return 1 if it had an effect
        function bit note_item(logic cmd, logic [FREQ_BITS-1:0] f, logic [MS_BITS-1:0] ms,
                               logic [VOL_BITS-1:0] vol);
            logic [63:0]                count;
            logic [63:0]                mag;
            logic [63:0]                scaled;
            logic [VOL_BITS-1:0]        vol_clamped;
            logic [1:0]                 quad;
            logic [TABLE_ADDR_BITS-1:0] idx;
            tone_sample_t               predicted;
            if (cmd == CMD_START)
            begin
                if (f == 0 || ms == 0)
                begin
                    return 1'b0;
                end
                count = (64'(SAMPLE_RATE) * 64'(ms)) / 64'(MS_PER_S);
                if (count > 64'(COUNT_MAX))
                begin
                    count = 64'(COUNT_MAX);
                end
                if (count == 0)
                begin
                    return 1'b0;
                end
                vol_clamped = (vol > VOL_MAX) ? VOL_BITS'(VOL_MAX) : vol;
                step      = PHASE_BITS'((64'(f) << PHASE_BITS) / 64'(SAMPLE_RATE));
                remaining = COUNT_BITS'(count);
                amp       = AMP_BITS'((64'(FULL_SCALE) * 64'(vol_clamped)) / 64'(VOL_MAX));
                phase     = '0;
                active    = 1'b1;
                return 1'b1;
            end
            if (!active)
            begin
                return 1'b0;
            end
            quad = phase[PHASE_BITS-1 -: 2];
            idx  = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
            mag  = quad[0] ? 64'(sine_mag[TABLE_SIZE - int'(idx)]) : 64'(sine_mag[idx]);
            scaled = (64'(amp) * mag) / 64'(FULL_SCALE);
            predicted.sample = quad[1] ? -SAMPLE_BITS'(scaled) : SAMPLE_BITS'(scaled);
            phase     = phase + step;
            remaining = remaining - 1'b1;
            predicted.last = (remaining == 0);
            if (predicted.last)
            begin
                active = 1'b0;
            end
            due_samples.push_back(predicted);
            return 1'b1;
        endfunction

        function void check_sample(logic signed [SAMPLE_BITS-1:0] got_sample, logic got_last);
            tone_sample_t want;
            if (due_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected sample %0d last %0b at %0t", got_sample, got_last,
                             $realtime);
                end
                return;
            end
            want = due_samples.pop_front();
            if (want.sample !== got_sample || want.last !== got_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("sample mismatch at %0t: expected %0d last %0b, got %0d last %0b",
                             $realtime, want.sample, want.last, got_sample, got_last);
                end
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          tone_valid   = 1'b0;
    logic                          tone_ready;
    logic                          command      = CMD_TICK;
    logic [FREQ_BITS-1:0]          freq_hz      = '0;
    logic [MS_BITS-1:0]            length_ms    = '0;
    logic [VOL_BITS-1:0]           level_pct    = '0;
    logic                          sample_valid;
    logic                          sample_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    tone_scoreboard sb;
    bit             fast_mode;
    bit             hold_off_req;
    int             applied;

    sine_tone_generator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tone_valid   (tone_valid),
        .tone_ready   (tone_ready),
        .command      (command),
        .freq_hz      (freq_hz),
        .length_ms    (length_ms),
        .level_pct    (level_pct),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            sb.check_sample(sample, last);
        end
    end

    // Sample receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                sample_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_req = 1'b0;
            end
            stall = fast_mode ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                sample_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            sample_ready <= 1'b1;
            do @(posedge clk); while (!sample_valid);
        end
    end

    // Keep valid high across back-to-back transfers; drop it only for a gap
    task automatic send_item(logic cmd, logic [FREQ_BITS-1:0] f, logic [MS_BITS-1:0] ms,
                             logic [VOL_BITS-1:0] vol);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            tone_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tone_valid <= 1'b1;
        command    <= cmd;
        freq_hz    <= f;
        length_ms  <= ms;
        level_pct  <= vol;
        do @(posedge clk); while (!tone_ready);
        if (sb.note_item(cmd, f, ms, vol))
        begin
            applied++;
        end
    endtask

    // Tick fields carry random junk that the block must ignore
    task automatic send_ticks(int unsigned n);
        repeat (n)
        begin
            send_item(CMD_TICK, FREQ_BITS'($urandom), MS_BITS'($urandom), VOL_BITS'($urandom));
        end
    endtask

    initial
    begin
        logic [FREQ_BITS-1:0] f;
        logic [MS_BITS-1:0]   ms;
        int unsigned          count;
        int unsigned          ticks;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_ticks(1);                                   // tick while idle
        send_item(CMD_START, 16'd0, 16'd5, 8'd50);       // zero frequency, dropped
        send_item(CMD_START, 16'd440, 16'd0, 8'd50);     // zero duration, dropped
        send_item(CMD_START, 16'hFFFF, 16'hFFFF, 8'hFF); // aliased step, longest tone, clamp
        send_ticks(2);
        send_item(CMD_START, 16'd0, 16'hFFFF, 8'd1);     // dropped, tone keeps running
        send_ticks(1);
        send_item(CMD_START, 16'd1000, 16'd0, 8'd0);
        send_ticks(1);
        send_item(CMD_START, 16'd4000, 16'd1, 8'd100);   // restart, lands on quadrant edges
        send_ticks(17);                                  // full tone, then an idle tick

        // Back the block up: receiver holds while ticks keep coming
        fast_mode    = 1'b1;
        hold_off_req = 1'b1;
        send_item(CMD_START, 16'd1234, 16'd10, 8'd77);
        send_ticks(100);
        fast_mode = 1'b0;

        while (applied < ITEM_TARGET)
        begin
            fast_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                f  = $urandom_range(0, 1) ? 16'd0 : FREQ_BITS'($urandom);
                ms = (f == 0 && $urandom_range(0, 1)) ? MS_BITS'($urandom) : 16'd0;
                send_item(1'($urandom), f, ms, VOL_BITS'($urandom));
            end
            else
            begin
                f  = $urandom_range(0, 1) ? 16'($urandom_range(1, SAMPLE_RATE / 2))
                                          : 16'($urandom_range(1, 65535));
                ms = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                                 : 16'($urandom_range(1, 3));
                count = (SAMPLE_RATE * int'(ms)) / MS_PER_S;
                send_item(CMD_START, f, ms, VOL_BITS'($urandom));
                if (ms > 3)
                begin
                    ticks = $urandom_range(5, 40);
                end
                else if ($urandom_range(0, 4) == 0)
                begin
                    ticks = $urandom_range(1, count);
                end
                else
                begin
                    ticks = count + $urandom_range(0, 2);
                end
                send_ticks(ticks);
            end
        end
        fast_mode = 1'b0;
        tone_valid <= 1'b0;

        while (sb.due_samples.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.due_samples.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
